FILE: sv/bstmc_pkg.sv
// ----------------------------------------------------------------------------
// bstmc_pkg: shared types and constants
// constants, op codes, state encoding and the slot hash for the stamp table unit
// ----------------------------------------------------------------------------
`default_nettype none
package bstmc_pkg;
    localparam int TABLE_INDEX_BITS = 12;
    localparam int SAMPLE_SLOTS     = 8;
    localparam int PHASE_BUCKETS    = 16;
    localparam int COUNTER_BITS     = 48;
    localparam int ADDR_W           = 48;
    localparam logic [63:0] GOLDEN  = 64'h9e3779b97f4a7c15;

    localparam logic [1:0] OP_NOTE     = 2'd0;
    localparam logic [1:0] OP_CLASSIFY = 2'd1;
    localparam logic [1:0] OP_READ     = 2'd2;
    localparam logic [1:0] OP_CLEAR    = 2'd3;

    localparam logic [1:0] MK_NONE  = 2'd0;
    localparam logic [1:0] MK_BARE  = 2'd1;
    localparam logic [1:0] MK_LOST  = 2'd2;
    localparam logic [1:0] MK_EARLY = 2'd3;

    localparam logic [4:0] RD_NOTES  = 5'd0;
    localparam logic [4:0] RD_WRAPS  = 5'd1;
    localparam logic [4:0] RD_MISS0  = 5'd2;
    localparam logic [4:0] RD_BUCKET = 5'd8;
    localparam logic [4:0] RD_SAMPLE = 5'd24;

    // config register indexes
    localparam logic CFG_ENABLE = 1'b0;
    localparam logic CFG_LIMIT  = 1'b1;

    // census counter slots, in read order after RD_MISS0
    localparam int MC_MISS  = 0;
    localparam int MC_BARE  = 1;
    localparam int MC_LOW   = 2;
    localparam int MC_HIGH  = 3;
    localparam int MC_LOST  = 4;
    localparam int MC_EARLY = 5;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_HASH  = 7'b0000100,
        S_MUL   = 7'b0001000,
        S_READ  = 7'b0010000,
        S_EXEC  = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clr_step;   // clear one table slot per cycle
        logic load;       // capture input item
        logic hash;       // folded address stage
        logic mul;        // multiply stage, table read issued
        logic exec;       // update state and build result
    } t_cmd;

    typedef struct packed {
        logic clr_done;
    } t_sts;
endpackage
`default_nettype wire

FILE: sv/barrier_stamp_table_miss_classifier_unit.sv
// ----------------------------------------------------------------------------
// barrier_stamp_table_miss_classifier_unit: barrier stamp table and miss census
// ----------------------------------------------------------------------------
// sequence: an accepted item passes the hash fold, multiply and table read
//   issue, read data and update steps before its result is valid
// items: the sequencer walks each item through the single-port stamp memory
//   read-modify-write and takes no new item until the last result is taken
// reset: synchronous active low; afterwards the stamp memory is cleared one
//   slot a cycle, every slot in turn, before the first item is taken
// ----------------------------------------------------------------------------
`default_nettype none
module barrier_stamp_table_miss_classifier_unit #(
    parameter int TABLE_INDEX_BITS = bstmc_pkg::TABLE_INDEX_BITS,
    parameter int SAMPLE_SLOTS     = bstmc_pkg::SAMPLE_SLOTS,
    parameter int PHASE_BUCKETS    = bstmc_pkg::PHASE_BUCKETS,
    parameter int COUNTER_BITS     = bstmc_pkg::COUNTER_BITS
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // config write port: index 0 enable, 1 init_phase_limit
    input  wire         i_cfg_we,
    input  wire         i_cfg_index,
    input  wire [7:0]   i_cfg_data,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // op[1:0], field_address[49:2], phase[57:50], recorded[58],
    // counter_index[63:59]
    input  wire [63:0]  s_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // accepted[0], found[1], stamp_phase[9:2], stamp_recorded[10],
    // overwrote_other[11], miss_kind[13:12], above_limit[14],
    // phase_bucket[18:15], sample_count[22:19], read_value[70:23], zero pad
    output logic [71:0] m_axis_tdata
);
    logic       r_enable;
    logic [7:0] r_limit;
    logic [71:0] w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_limit  <= 8'd8;
        end else if (i_cfg_we) begin
            if (i_cfg_index == bstmc_pkg::CFG_LIMIT) r_limit <= i_cfg_data;
            else r_enable <= i_cfg_data[0];
        end
    end

    bstmc_pkg::t_cmd w_cmd;
    bstmc_pkg::t_sts w_sts;

    bstmc_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    bstmc_dp #(
        .TABLE_INDEX_BITS (TABLE_INDEX_BITS),
        .SAMPLE_SLOTS     (SAMPLE_SLOTS),
        .PHASE_BUCKETS    (PHASE_BUCKETS),
        .COUNTER_BITS     (COUNTER_BITS)
    ) u_dp (
        .i_clk, .i_rst_n,
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_enable        (r_enable),
        .i_limit         (r_limit),
        .i_op            (s_axis_tdata[1:0]),
        .i_addr          (s_axis_tdata[49:2]),
        .i_phase         (s_axis_tdata[57:50]),
        .i_recorded      (s_axis_tdata[58]),
        .i_counter_index (s_axis_tdata[63:59]),
        .o_result        (w_res)
    );

    // datapath word has sample_count at [23:20] and read_value at [71:24];
    // repack without gaps
    assign m_axis_tdata = {1'b0, w_res[71:24], w_res[23:20], w_res[18:0]};
endmodule
`default_nettype wire

FILE: sv/bstmc_ctrl.sv
// ----------------------------------------------------------------------------
// bstmc_ctrl: sequencer
// walks one item through hash, multiply, table read and update steps
// ----------------------------------------------------------------------------
`default_nettype none
module bstmc_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    input  bstmc_pkg::t_sts     i_sts,
    output bstmc_pkg::t_cmd     o_cmd
);
    bstmc_pkg::t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            bstmc_pkg::S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) n_state = bstmc_pkg::S_IDLE;
            end
            bstmc_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = bstmc_pkg::S_HASH;
                end
            end
            bstmc_pkg::S_HASH: begin
                o_cmd.hash = 1'b1;
                n_state = bstmc_pkg::S_MUL;
            end
            bstmc_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = bstmc_pkg::S_READ;
            end
            bstmc_pkg::S_READ: n_state = bstmc_pkg::S_EXEC;
            bstmc_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state = bstmc_pkg::S_OUT;
            end
            bstmc_pkg::S_OUT: begin
                if (i_out_ready) n_state = bstmc_pkg::S_IDLE;
            end
            default: n_state = bstmc_pkg::S_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == bstmc_pkg::S_IDLE);
    assign o_out_valid = (r_state == bstmc_pkg::S_OUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bstmc_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
`default_nettype wire

FILE: sv/bstmc_dp.sv
// ----------------------------------------------------------------------------
// bstmc_dp: datapath
// stamp memory, counters, samples and result formation
// ----------------------------------------------------------------------------
`default_nettype none
module bstmc_dp #(
    parameter int TABLE_INDEX_BITS = bstmc_pkg::TABLE_INDEX_BITS,
    parameter int SAMPLE_SLOTS     = bstmc_pkg::SAMPLE_SLOTS,
    parameter int PHASE_BUCKETS    = bstmc_pkg::PHASE_BUCKETS,
    parameter int COUNTER_BITS     = bstmc_pkg::COUNTER_BITS
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  bstmc_pkg::t_cmd  i_cmd,
    output bstmc_pkg::t_sts  o_sts,
    input  wire              i_enable,
    input  wire [7:0]        i_limit,
    input  wire [1:0]        i_op,
    input  wire [47:0]       i_addr,
    input  wire [7:0]        i_phase,
    input  wire              i_recorded,
    input  wire [4:0]        i_counter_index,
    output logic [71:0]      o_result
);
    localparam int DEPTH = 1 << TABLE_INDEX_BITS;
    localparam int SW    = $clog2(SAMPLE_SLOTS + 1);
    localparam int SIW   = (SAMPLE_SLOTS > 1) ? $clog2(SAMPLE_SLOTS) : 1;
    localparam int BW    = (PHASE_BUCKETS > 1) ? $clog2(PHASE_BUCKETS) : 1;
    localparam logic [COUNTER_BITS-1:0] CMAX = '1;
    localparam int EW    = 57;
    // low index bits of the product depend only on the low operand bits
    localparam logic [TABLE_INDEX_BITS-1:0] GOLD_LO =
        bstmc_pkg::GOLDEN[TABLE_INDEX_BITS-1:0];

    function automatic logic [COUNTER_BITS-1:0] sat_inc(input logic [COUNTER_BITS-1:0] c);
        sat_inc = (c == CMAX) ? c : c + 1'b1;
    endfunction

    logic [EW-1:0] r_mem [DEPTH];
    logic [EW-1:0] r_rd;
    logic [TABLE_INDEX_BITS:0] r_clr;

    logic [1:0]  r_op;
    logic [47:0] r_addr;
    logic [7:0]  r_phase;
    logic        r_rec;
    logic [4:0]  r_idx;
    logic [TABLE_INDEX_BITS-1:0] r_fold;
    logic [TABLE_INDEX_BITS-1:0] r_slot;

    logic [COUNTER_BITS-1:0] r_notes, r_wraps;
    logic [COUNTER_BITS-1:0] r_mc [6];
    logic [COUNTER_BITS-1:0] r_bk [PHASE_BUCKETS];
    logic [47:0]             r_smp [SAMPLE_SLOTS];
    logic [SW-1:0]           r_kept;

    logic [TABLE_INDEX_BITS-1:0] w_prod;
    assign w_prod = r_fold * GOLD_LO;

    assign o_sts.clr_done = r_clr[TABLE_INDEX_BITS];

    // table view
    logic [47:0] w_tag;
    logic [7:0]  w_sp;
    logic        w_srec, w_found, w_above, w_wrap;
    logic [7:0]  w_bucket;
    assign w_tag   = r_rd[47:0];
    assign w_sp    = r_rd[55:48];
    assign w_srec  = r_rd[56];
    assign w_found = (w_tag != 48'd0) && (w_tag == r_addr);
    assign w_above = w_found && (w_sp > i_limit);
    assign w_wrap  = (w_tag != 48'd0) && (w_tag != r_addr);
    assign w_bucket = (w_found && ({24'd0, w_sp} < PHASE_BUCKETS)) ? w_sp : 8'd0;

    logic w_note_ok, w_cls_ok, w_room;
    assign w_note_ok = (r_op == bstmc_pkg::OP_NOTE) && i_enable && (r_addr != 48'd0);
    assign w_cls_ok  = (r_op == bstmc_pkg::OP_CLASSIFY) && i_enable;
    assign w_room    = (32'(r_kept) < SAMPLE_SLOTS);

    // read selection
    logic [47:0] w_rsel;
    logic [4:0] w_boff, w_soff;
    always_comb begin
        w_boff = r_idx - bstmc_pkg::RD_BUCKET;
        w_soff = r_idx - bstmc_pkg::RD_SAMPLE;
        w_rsel = '0;
        if (r_idx == bstmc_pkg::RD_NOTES) w_rsel = 48'(r_notes);
        else if (r_idx == bstmc_pkg::RD_WRAPS) w_rsel = 48'(r_wraps);
        else if (r_idx < bstmc_pkg::RD_BUCKET)
            w_rsel = 48'(r_mc[3'(r_idx - bstmc_pkg::RD_MISS0)]);
        else if (r_idx < bstmc_pkg::RD_SAMPLE) begin
            if ({27'd0, w_boff} < PHASE_BUCKETS) w_rsel = 48'(r_bk[BW'(w_boff)]);
        end else if (({27'd0, w_soff} < SAMPLE_SLOTS) && ({27'd0, w_soff} < 32'(r_kept))) begin
            w_rsel = r_smp[SIW'(w_soff)];
        end
    end

    // result word for the item in the update step
    logic [71:0] n_result;
    always_comb begin
        n_result = '0;
        n_result[23:20] = 4'(r_kept);
        unique case (r_op)
            bstmc_pkg::OP_NOTE: begin
                if (w_note_ok) begin
                    n_result[0]  = 1'b1;
                    n_result[11] = w_wrap;
                end
            end
            bstmc_pkg::OP_CLASSIFY: begin
                if (w_cls_ok) begin
                    n_result[0] = 1'b1;
                    if (!w_found) begin
                        n_result[13:12] = bstmc_pkg::MK_BARE;
                    end else begin
                        n_result[1]     = 1'b1;
                        n_result[9:2]   = w_sp;
                        n_result[10]    = w_srec;
                        n_result[13:12] = w_srec ? bstmc_pkg::MK_LOST : bstmc_pkg::MK_EARLY;
                    end
                    n_result[14]    = w_above;
                    n_result[18:15] = w_bucket[3:0];
                    if (w_room) n_result[23:20] = 4'(r_kept + 1'b1);
                end
            end
            bstmc_pkg::OP_READ: begin
                n_result[0]      = 1'b1;
                n_result[71:24]  = w_rsel;
            end
            bstmc_pkg::OP_CLEAR: begin
                n_result[0]     = 1'b1;
                n_result[23:20] = 4'd0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_op; r_addr <= i_addr; r_phase <= i_phase;
            r_rec <= i_recorded; r_idx <= i_counter_index;
        end
        // low index bits of (a ^ a >> 17) with a = addr >> 3
        if (i_cmd.hash)
            r_fold <= r_addr[TABLE_INDEX_BITS+2:3] ^ r_addr[TABLE_INDEX_BITS+19:20];
        if (i_cmd.mul) begin
            r_slot <= w_prod;
            r_rd   <= r_mem[w_prod];
        end
        if (i_cmd.clr_step && !r_clr[TABLE_INDEX_BITS])
            r_mem[r_clr[TABLE_INDEX_BITS-1:0]] <= '0;
        else if (i_cmd.exec && w_note_ok)
            r_mem[r_slot] <= {r_rec, r_phase, r_addr};
        if (i_cmd.exec && w_cls_ok && w_room)
            r_smp[SIW'(r_kept)] <= r_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
            r_notes <= '0; r_wraps <= '0; r_kept <= '0;
            for (int i = 0; i < 6; i++) r_mc[i] <= '0;
            for (int i = 0; i < PHASE_BUCKETS; i++) r_bk[i] <= '0;
            o_result <= '0;
        end else begin
            if (i_cmd.clr_step && !r_clr[TABLE_INDEX_BITS]) r_clr <= r_clr + 1'b1;
            if (i_cmd.exec) begin
                o_result <= n_result;
                unique case (r_op)
                    bstmc_pkg::OP_NOTE: begin
                        if (w_note_ok) begin
                            r_notes <= sat_inc(r_notes);
                            if (w_wrap) r_wraps <= sat_inc(r_wraps);
                        end
                    end
                    bstmc_pkg::OP_CLASSIFY: begin
                        if (w_cls_ok) begin
                            r_mc[bstmc_pkg::MC_MISS] <= sat_inc(r_mc[bstmc_pkg::MC_MISS]);
                            if (!w_found) begin
                                r_mc[bstmc_pkg::MC_BARE] <= sat_inc(r_mc[bstmc_pkg::MC_BARE]);
                            end else begin
                                if (w_srec)
                                    r_mc[bstmc_pkg::MC_LOST] <=
                                        sat_inc(r_mc[bstmc_pkg::MC_LOST]);
                                else
                                    r_mc[bstmc_pkg::MC_EARLY] <=
                                        sat_inc(r_mc[bstmc_pkg::MC_EARLY]);
                                if (w_above)
                                    r_mc[bstmc_pkg::MC_HIGH] <=
                                        sat_inc(r_mc[bstmc_pkg::MC_HIGH]);
                                else
                                    r_mc[bstmc_pkg::MC_LOW] <=
                                        sat_inc(r_mc[bstmc_pkg::MC_LOW]);
                            end
                            r_bk[BW'(w_bucket)] <= sat_inc(r_bk[BW'(w_bucket)]);
                            if (w_room) r_kept <= r_kept + 1'b1;
                        end
                    end
                    bstmc_pkg::OP_READ: ;
                    bstmc_pkg::OP_CLEAR: begin
                        for (int i = 0; i < 6; i++) r_mc[i] <= '0;
                        for (int i = 0; i < PHASE_BUCKETS; i++) r_bk[i] <= '0;
                        r_kept <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end
endmodule
`default_nettype wire
